FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define A_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define A_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/rsrg_pkg.sv
// Package: types and constants of the replacement selection run generator
package rsrg_pkg;
    localparam int unsigned ValW = 32;
    localparam int unsigned RunW = 16;
    localparam int unsigned CfgW = 11;
    localparam logic [RunW-1:0] RunMax = 16'hFFFF;

    typedef enum logic {
        t_cmd_push  = 1'b0,
        t_cmd_drain = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_LAST,
        S_DN_RD,
        S_DN_C1,
        S_DN_C2,
        S_DN_CMP,
        S_UP,
        S_UP_C,
        S_OUT
    } t_state;

    typedef struct packed {
        logic           cmd;
        logic [ValW-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [ValW-1:0] out_value;
        logic [RunW-1:0] run_num;
        logic            run_start;
        logic            empty_res;
    } t_out_beat;

    // ordering key: relative run above offset-binary value
    function automatic logic [ValW:0] key_of(logic tag, logic run_lsb, logic [ValW-1:0] v);
        key_of = {tag ^ run_lsb, v ^ 32'h8000_0000};
    endfunction
endpackage

FILE: rtl/core/rsrg_if.sv
// Valid/ready channel interfaces for input and result beats
interface rsrg_in_if;
    logic                valid;
    logic                ready;
    rsrg_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsrg_out_if;
    logic                valid;
    logic                ready;
    rsrg_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/replacement_selection_run_generator_unit.sv
// Top level: replacement selection run generator over a memory-based min-heap
// A push into a full heap pops the root into a result and sifts the new element down (one shared
// comparator, one read port); a drain pops the root and sifts the last element down, and a drain
// of an empty heap gives an empty result; each result may wait for the output register to empty.
// A push into a non-full heap sifts up and gives no result; a new beat is taken only in idle.
// Synchronous active-low reset clears occupancy and run counter and sets heap size to 1024.
module replacement_selection_run_generator_unit #(
    parameter int unsigned HEAP_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rsrg_pkg::CfgW-1:0] i_cfg_wdata,
    rsrg_in_if.sink                   i_in,
    rsrg_out_if.source                o_out
);
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned OW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned SW = (OW > rsrg_pkg::CfgW) ? OW : rsrg_pkg::CfgW;
    localparam int unsigned CW = AW + 2;
    localparam int unsigned RW = rsrg_pkg::RunW;
    localparam int unsigned FW = rsrg_pkg::CfgW;

    rsrg_pkg::t_state r_state, n_state;
    logic [OW-1:0]   r_occ, n_occ;
    logic [RW-1:0]   r_run, n_run;
    logic            r_emitted, n_emitted;
    logic [FW-1:0]   r_size;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_cidx, n_cidx;
    logic [32:0]     r_elem, n_elem;
    logic [32:0]     r_child, n_child;
    logic [31:0]     r_val, n_val;
    logic            r_drain, n_drain;
    rsrg_pkg::t_out_beat r_res, n_res;
    rsrg_pkg::t_out_beat r_out, n_out;
    logic            r_ovalid, n_ovalid;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [32:0]     wdata, rdata;
    logic [SW-1:0]   lim;
    logic [CW-1:0]   c1, c2;
    logic [AW-1:0]   par;
    logic [RW-1:0]   nxt_run, pop_run;
    logic            pop_adv, pop_tag_next;
    logic [32:0]     cmp_a, cmp_b;
    logic            cmp_le;

    rsrg_heap_ram #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        lim = SW'(r_size);
        if (r_size == '0) lim = SW'(1);
        if (SW'(r_size) > SW'(HEAP_DEPTH)) lim = SW'(HEAP_DEPTH);
    end

    assign nxt_run      = (r_run == rsrg_pkg::RunMax) ? r_run : r_run + RW'(1);
    assign pop_adv      = rdata[32] ^ r_run[0];
    assign pop_run      = pop_adv ? nxt_run : r_run;
    assign pop_tag_next = (pop_run == rsrg_pkg::RunMax) ? pop_run[0] : ~pop_run[0];
    assign c1           = {1'b0, r_idx, 1'b1};
    assign c2           = c1 + CW'(1);
    assign par          = (r_idx - AW'(1)) >> 1;
    assign cmp_le       = (cmp_a <= cmp_b);
    assign i_in.ready   = (r_state == rsrg_pkg::S_IDLE);
    assign o_out.valid  = r_ovalid;
    assign o_out.data   = r_out;

    // shared comparator operands
    always_comb begin
        cmp_a = rsrg_pkg::key_of(r_elem[32], r_run[0], r_elem[31:0]);
        cmp_b = rsrg_pkg::key_of(r_child[32], r_run[0], r_child[31:0]);
        case (r_state)
            rsrg_pkg::S_POP: begin
                cmp_a = rsrg_pkg::key_of(1'b0, 1'b0, rdata[31:0]);
                cmp_b = rsrg_pkg::key_of(1'b0, 1'b0, r_val);
            end
            rsrg_pkg::S_DN_C2: begin
                cmp_a = rsrg_pkg::key_of(r_child[32], r_run[0], r_child[31:0]);
                cmp_b = rsrg_pkg::key_of(rdata[32], r_run[0], rdata[31:0]);
            end
            rsrg_pkg::S_UP_C: begin
                cmp_a = rsrg_pkg::key_of(rdata[32], r_run[0], rdata[31:0]);
                cmp_b = rsrg_pkg::key_of(r_elem[32], r_run[0], r_elem[31:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsrg_pkg::S_IDLE;
            r_occ     <= '0;
            r_run     <= '0;
            r_emitted <= 1'b0;
            r_size    <= FW'(1024);
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_run     <= n_run;
            r_emitted <= n_emitted;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
        r_elem  <= n_elem;
        r_child <= n_child;
        r_val   <= n_val;
        r_drain <= n_drain;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_run     = r_run;
        n_emitted = r_emitted;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_elem    = r_elem;
        n_child   = r_child;
        n_val     = r_val;
        n_drain   = r_drain;
        n_res     = r_res;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = r_elem;
        raddr     = '0;
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            rsrg_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_val   = i_in.data.value;
                    n_drain = (i_in.data.cmd == rsrg_pkg::t_cmd_drain);
                    if (i_in.data.cmd == rsrg_pkg::t_cmd_drain) begin
                        if (r_occ == '0) begin
                            n_res = '{out_value: '0, run_num: r_run,
                                      run_start: 1'b0, empty_res: 1'b1};
                            n_state = rsrg_pkg::S_OUT;
                        end else begin
                            n_state = rsrg_pkg::S_POP;
                        end
                    end else if (SW'(r_occ) < lim) begin
                        n_elem  = {r_run[0], i_in.data.value};
                        n_idx   = AW'(r_occ);
                        n_occ   = r_occ + OW'(1);
                        n_state = rsrg_pkg::S_UP;
                    end else begin
                        n_state = rsrg_pkg::S_POP;
                    end
                end
            end
            rsrg_pkg::S_POP: begin
                // root arrived: build result, advance run
                n_res.out_value = rdata[31:0];
                n_res.run_num   = pop_run;
                n_res.run_start = !r_emitted || pop_adv;
                n_res.empty_res = 1'b0;
                n_run     = pop_run;
                n_emitted = 1'b1;
                n_idx     = '0;
                if (r_drain) begin
                    n_occ = r_occ - OW'(1);
                    if (r_occ == OW'(1)) begin
                        n_state = rsrg_pkg::S_OUT;
                    end else begin
                        raddr   = AW'(r_occ - OW'(1));
                        n_state = rsrg_pkg::S_LAST;
                    end
                end else begin
                    n_elem  = {(cmp_le ? pop_run[0] : pop_tag_next), r_val};
                    n_state = rsrg_pkg::S_DN_RD;
                end
            end
            rsrg_pkg::S_LAST: begin
                n_elem  = rdata;
                n_state = rsrg_pkg::S_DN_RD;
            end
            rsrg_pkg::S_DN_RD: begin
                if (c1 >= CW'(r_occ)) begin
                    we      = 1'b1;
                    n_state = rsrg_pkg::S_OUT;
                end else begin
                    raddr   = AW'(c1);
                    n_state = rsrg_pkg::S_DN_C1;
                end
            end
            rsrg_pkg::S_DN_C1: begin
                n_child = rdata;
                n_cidx  = AW'(c1);
                if (c2 < CW'(r_occ)) begin
                    raddr   = AW'(c2);
                    n_state = rsrg_pkg::S_DN_C2;
                end else begin
                    n_state = rsrg_pkg::S_DN_CMP;
                end
            end
            rsrg_pkg::S_DN_C2: begin
                if (!cmp_le) begin
                    n_child = rdata;
                    n_cidx  = AW'(c2);
                end
                n_state = rsrg_pkg::S_DN_CMP;
            end
            rsrg_pkg::S_DN_CMP: begin
                we = 1'b1;
                if (cmp_le) begin
                    n_state = rsrg_pkg::S_OUT;
                end else begin
                    wdata   = r_child;
                    n_idx   = r_cidx;
                    n_state = rsrg_pkg::S_DN_RD;
                end
            end
            rsrg_pkg::S_UP: begin
                if (r_idx == '0) begin
                    we      = 1'b1;
                    n_state = rsrg_pkg::S_IDLE;
                end else begin
                    raddr   = par;
                    n_state = rsrg_pkg::S_UP_C;
                end
            end
            rsrg_pkg::S_UP_C: begin
                we = 1'b1;
                if (cmp_le) begin
                    n_state = rsrg_pkg::S_IDLE;
                end else begin
                    wdata   = rdata;
                    n_idx   = par;
                    n_state = rsrg_pkg::S_UP;
                end
            end
            rsrg_pkg::S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = rsrg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsrg_pkg::S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/core/rsrg_heap_ram.sv
// Heap store: single write port, one registered read port
module rsrg_heap_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [32:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [32:0]   o_rdata
);
    logic [32:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/core/rsrg_checker.sv
// Port-level checker for the run generator, bound to the top level
`include "assert_macros.svh"
module rsrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_empty_res,
    input logic        i_run_start,
    input logic [15:0] i_run_num
);
    logic out_stall;

    assign out_stall = i_out_valid && !i_out_ready;

    `A_IMPLIES(a_empty_no_start, i_clk, i_rst_n, i_out_valid && i_empty_res, !i_run_start)
    `A_NEXT(a_out_holds, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_run_num))
    `A_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
endmodule

bind replacement_selection_run_generator_unit rsrg_checker u_rsrg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_empty_res(o_out.data.empty_res), .i_run_start(o_out.data.run_start),
    .i_run_num(o_out.data.run_num)
);

FILE: dv/tb_replacement_selection_run_generator_unit.sv
// Testbench: replacement selection run generator checked beat by beat against its own heap model
module tb_replacement_selection_run_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned VW = rsrg_pkg::ValW;
    localparam int unsigned RW = rsrg_pkg::RunW;
    localparam int unsigned FW = rsrg_pkg::CfgW;
    localparam int unsigned SETTLE = 64;
    localparam longint unsigned CYCLE_LIMIT = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [FW-1:0] i_cfg_wdata = '0;

    rsrg_in_if  in_if ();
    rsrg_out_if out_if ();

    replacement_selection_run_generator_unit #(.HEAP_DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    // heap model state
    logic [VW:0]     heap_mem [DEPTH];
    int unsigned     heap_fill;
    int unsigned     run_now;
    bit              emitted_any;
    logic [FW-1:0]   size_reg;

    rsrg_pkg::t_in_beat  pending_beats [$];
    rsrg_pkg::t_out_beat expected_beats [$];

    bit          in_fire;
    bit          idling_on = 1'b1;
    int          hold_request;
    int          send_gap;
    int          recv_gap;
    int          hold_left;
    int unsigned mismatches;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned max_run_seen;
    longint unsigned cycles;

    function automatic logic [VW:0] order_key(logic [VW:0] e);
        return {e[VW] ^ run_now[0], e[VW-1:0] ^ 32'h8000_0000};
    endfunction

    function automatic int unsigned next_run_of();
        return (run_now >= rsrg_pkg::RunMax) ? rsrg_pkg::RunMax : run_now + 1;
    endfunction

    function automatic void heap_push(logic [VW-1:0] v, int unsigned r);
        logic [VW:0] e;
        int unsigned i;
        int unsigned p;
        e = {r[0], v};
        if (heap_fill >= DEPTH) return;
        i = heap_fill;
        heap_fill++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (order_key(heap_mem[p]) <= order_key(e)) break;
            heap_mem[i] = heap_mem[p];
            i = p;
        end
        heap_mem[i] = e;
    endfunction

    function automatic logic [VW:0] heap_pop_min();
        logic [VW:0] top;
        logic [VW:0] e;
        int unsigned i;
        int unsigned c;
        top = heap_mem[0];
        i = 0;
        heap_fill--;
        if (heap_fill == 0) return top;
        e = heap_mem[heap_fill];
        forever begin
            c = 2 * i + 1;
            if (c >= heap_fill) break;
            if (c + 1 < heap_fill && order_key(heap_mem[c+1]) < order_key(heap_mem[c])) c++;
            if (order_key(e) <= order_key(heap_mem[c])) break;
            heap_mem[i] = heap_mem[c];
            i = c;
        end
        heap_mem[i] = e;
        return top;
    endfunction

    function automatic rsrg_pkg::t_out_beat take_smallest();
        logic [VW:0] e;
        bit adv;
        rsrg_pkg::t_out_beat b;
        e = heap_pop_min();
        adv = e[VW] ^ run_now[0];
        b.run_start = !emitted_any || adv;
        if (adv) run_now = next_run_of();
        emitted_any = 1'b1;
        b.out_value = e[VW-1:0];
        b.run_num = run_now[RW-1:0];
        b.empty_res = 1'b0;
        return b;
    endfunction

    function automatic void predict_beat(rsrg_pkg::t_in_beat ib);
        int unsigned cap;
        rsrg_pkg::t_out_beat b;
        cap = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
        if (ib.cmd == rsrg_pkg::t_cmd_push) begin
            if (heap_fill < cap) begin
                heap_push(ib.value, run_now);
                return;
            end
            b = take_smallest();
            if ($signed(ib.value) >= $signed(b.out_value)) heap_push(ib.value, run_now);
            else heap_push(ib.value, next_run_of());
        end else if (heap_fill == 0) begin
            b.out_value = '0;
            b.run_num = run_now[RW-1:0];
            b.run_start = 1'b0;
            b.empty_res = 1'b1;
        end else begin
            b = take_smallest();
        end
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // input side
    always @(posedge i_clk) begin
        in_fire <= in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            predict_beat(in_if.data);
            beats_in++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
        end else if (!in_if.valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                in_if.data <= pending_beats.pop_front();
                in_if.valid <= 1'b1;
                if (idling_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 15);
        end
    end

    always @(posedge i_clk) begin
        rsrg_pkg::t_out_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            beats_out++;
            if (out_if.data.run_num > max_run_seen) max_run_seen = out_if.data.run_num;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d run %0d start %0b empty %0b",
                             $signed(out_if.data.out_value), out_if.data.run_num,
                             out_if.data.run_start, out_if.data.empty_res);
            end else begin
                want = expected_beats.pop_front();
                if (out_if.data.empty_res !== want.empty_res
                    || out_if.data.run_num !== want.run_num
                    || out_if.data.run_start !== want.run_start
                    || out_if.data.out_value !== want.out_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp val %0d run %0d st %0b em %0b, %s %0d %0d %0b %0b",
                                 $signed(want.out_value), want.run_num, want.run_start,
                                 want.empty_res, "got val/run/st/em",
                                 $signed(out_if.data.out_value), out_if.data.run_num,
                                 out_if.data.run_start, out_if.data.empty_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_push(logic [VW-1:0] v);
        rsrg_pkg::t_in_beat b;
        b.cmd = rsrg_pkg::t_cmd_push;
        b.value = v;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic add_drain();
        rsrg_pkg::t_in_beat b;
        b.cmd = rsrg_pkg::t_cmd_drain;
        b.value = {$urandom()};
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_beats.size() > 0 || in_if.valid || !in_if.ready
               || expected_beats.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [FW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        size_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_value(ref logic [VW-1:0] walk);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 40) - 20;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: begin
                walk = walk + $urandom_range(0, 1000) - 150;
                return walk;
            end
        endcase
    endfunction

    task automatic random_phase(logic [FW-1:0] sz, int n, int drains, bit squeeze);
        logic [VW-1:0] walk;
        walk = $urandom();
        write_size(sz);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 6) == 0) add_drain();
            else add_push(pick_value(walk));
        end
        if (squeeze) hold_request = 400;
        for (int k = 0; k < drains; k++) add_drain();
        wait_quiet();
    endtask

    initial begin
        logic [VW-1:0] walk;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        size_reg = 11'd1024;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_drain();
        add_push(32'h8000_0000);
        add_push(32'h7FFF_FFFF);
        add_push(32'h0000_0000);
        add_push(32'hFFFF_FFFF);
        repeat (5) add_drain();
        wait_quiet();
        write_size(11'd0);
        add_push(32'd5);
        add_push(32'd3);
        add_push(32'd9);
        add_push(32'h8000_0000);
        add_push(32'h7FFF_FFFF);
        add_drain();
        add_drain();
        add_push(32'd1);
        wait_quiet();
        write_size(11'd2047);
        add_push(32'd7);
        add_push(32'hFFFF_FFF0);
        add_drain();
        add_drain();
        add_drain();
        wait_quiet();

        random_phase(11'd1, 120, 3, 1'b0);
        random_phase(11'd4, 150, 6, 1'b1);
        random_phase(11'd16, 180, 18, 1'b0);
        random_phase(11'd3, 80, 5, 1'b0);
        random_phase(11'd64, 250, 0, 1'b0);
        random_phase(11'd5, 60, 70, 1'b0);

        // last stretch: full-size heap, no idling
        idling_on = 1'b0;
        walk = $urandom();
        write_size(11'd1024);
        for (int k = 0; k < 50; k++) add_push(pick_value(walk));
        for (int k = 0; k < 40; k++) add_drain();
        wait_quiet();

        $display("covered %0d input beats and %0d results, runs up to %0d,", beats_in,
                 beats_out, max_run_seen);
        $display("heap sizes 0 to 2047, shrinking below occupancy, empty drains, long stall");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: replacement_selection_run_generator_unit.f
+incdir+rtl/core
rtl/core/rsrg_pkg.sv
rtl/core/rsrg_if.sv
rtl/core/rsrg_heap_ram.sv
rtl/core/replacement_selection_run_generator_unit.sv
rtl/core/rsrg_checker.sv
dv/tb_replacement_selection_run_generator_unit.sv
